// ===== rtl/noc_pkg.sv =====
// Shared types, widths and codes for the nearest occupied cell search block.
package noc_pkg;

    // working width of rows, columns and edge positions (covers maps up to 1024)
    localparam int CW = 12;
    // width of corner and robot fields
    localparam int IN_W = 10;
    // width of configuration data
    localparam int CFG_W = 8;
    // edge interpolation numerator and divisor widths
    localparam int NW = 24;
    localparam int DW = 12;
    // squared coordinate difference and squared distance widths
    localparam int SQW = 22;
    localparam int D2W = 23;
    // result field widths
    localparam int DIST_W = 21;
    localparam int OUT_XW = 7;
    // request queue depth between front and back
    localparam int QDEPTH = 2;
    // default map capacity
    localparam int DEF_MAX_WIDTH = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    // saturated distance
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // operation codes
    typedef enum logic [1:0] {
        OP_LOAD_NEXT  = 2'd0,
        OP_LOAD_START = 2'd1,
        OP_QUERY      = 2'd2
    } op_t;

    // configuration register indexes
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
    } vtx_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                   is_query;
        logic                   at_start;
        logic                   occ;
        logic signed [IN_W-1:0] rx;
        logic signed [IN_W-1:0] ry;
        vtx_t                   c;
        vtx_t                   d;
        vtx_t                   e;
        vtx_t                   f;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [OUT_XW-1:0] x;
        logic [OUT_XW-1:0] y;
        logic [DIST_W-1:0] d2;
    } res_t;

    // widen a field coordinate to the working width
    function automatic logic signed [CW-1:0] sx(input logic signed [IN_W-1:0] v);
        return CW'(v);
    endfunction

endpackage

// ===== rtl/noc_front.sv =====
// Front end: accepts input requests, classifies them and queues them for the back end.
module noc_front import noc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             op,
    input  logic signed [7:0]      cell_value,
    input  logic signed [IN_W-1:0] robot_x,
    input  logic signed [IN_W-1:0] robot_y,
    input  logic signed [IN_W-1:0] corner_c_x,
    input  logic signed [IN_W-1:0] corner_c_y,
    input  logic signed [IN_W-1:0] corner_d_x,
    input  logic signed [IN_W-1:0] corner_d_y,
    input  logic signed [IN_W-1:0] corner_e_x,
    input  logic signed [IN_W-1:0] corner_e_y,
    input  logic signed [IN_W-1:0] corner_f_x,
    input  logic signed [IN_W-1:0] corner_f_y,
    output logic                   q_valid,
    output req_t                   q_req,
    input  logic                   q_pop
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    req_t            fifo_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    req_t            req_new;
    logic            keep;
    logic            push;
    logic            pop;

    // classify the incoming request; unused codes are dropped
    always_comb
    begin
        req_new          = '0;
        req_new.occ      = (cell_value != 8'sd0) && (cell_value != -8'sd1);
        req_new.rx       = robot_x;
        req_new.ry       = robot_y;
        req_new.c        = '{x: corner_c_x, y: corner_c_y};
        req_new.d        = '{x: corner_d_x, y: corner_d_y};
        req_new.e        = '{x: corner_e_x, y: corner_e_y};
        req_new.f        = '{x: corner_f_x, y: corner_f_y};
        keep             = 1'b1;
        case (op_t'(op))
            OP_LOAD_NEXT:  req_new.at_start = 1'b0;
            OP_LOAD_START: req_new.at_start = 1'b1;
            OP_QUERY:      req_new.is_query = 1'b1;
            default:       keep = 1'b0;
        endcase
    end

    assign in_stall = (count_reg == CNTW'(QDEPTH));
    assign push     = in_valid && !in_stall && keep;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_req    = fifo_reg[rd_ptr_reg];

    // advance queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold queued requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= req_new;
        end
    end

endmodule

// ===== rtl/noc_div.sv =====
// Serial restoring divider giving the floor quotient of a signed numerator by a positive divisor.
module noc_div import noc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 busy,
    output logic signed [CW-1:0] quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg;
    logic [NW-1:0]   mag_reg;
    logic [DW-1:0]   den_reg;
    logic            neg_reg;
    logic [DW:0]     shifted;
    logic            ge;
    logic [DW:0]     trial;
    logic [CW-1:0]   q_low;

    // one quotient bit per cycle
    assign shifted = {rem_reg, mag_reg[NW-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NW-1];
            mag_reg <= num[NW-1] ? NW'(-num) : NW'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[DW-1:0] : shifted[DW-1:0];
            mag_reg <= {mag_reg[NW-2:0], ge};
        end
    end

    // round toward minus infinity for negative numerators
    assign q_low = mag_reg[CW-1:0];
    assign quot  = neg_reg ? -($signed(q_low) + $signed(CW'(rem_reg != '0)))
                           : $signed(q_low);
    assign busy  = busy_reg;

endmodule

// ===== rtl/noc_back.sv =====
// Back end: holds the occupancy bits, applies loads and scans both triangles of a query.
module noc_back import noc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  req_t             q_req,
    output logic             q_pop,
    input  logic [CFG_W-1:0] map_width,
    input  logic [CFG_W-1:0] map_height,
    output logic             res_valid,
    output res_t             res,
    input  logic             res_ready
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW  = $clog2(CAP);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SORT  = 8'b00000010,
        S_ROW   = 8'b00000100,
        S_NUM   = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_SCAN  = 8'b00100000,
        S_DRAIN = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   tri_reg, tri_next;
    logic [AW:0] ptr_reg, ptr_next;
    logic   p1_valid_reg, p2_valid_reg;
    logic   best_hit_reg, best_hit_next;
    logic   o1_hit_reg, o1_hit_next;

    // occupancy store
    logic mem [CAP];
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] rd_addr;
    logic rd_bit_reg;

    // query context
    logic signed [CW-1:0] rx_reg, ry_reg, w_reg, h_reg;
    vtx_t c_reg, d_reg, e_reg, f_reg;
    vtx_t va_reg, vb_reg, vc_reg;
    logic signed [CW-1:0] y_reg, x_reg, hi_reg;
    logic signed [2*CW-1:0] pl1_reg, pl2_reg, ps1_reg, ps2_reg;
    logic signed [CW-1:0] hl_reg, hs_reg;
    logic [AW-1:0] base_reg;

    // scan pipeline
    logic signed [CW-1:0] p1_dx_reg, p1_dy_reg, p1_x_reg, p1_y_reg;
    logic [SQW-1:0] sqx_reg, sqy_reg;
    logic p2_occ_reg;
    logic signed [CW-1:0] p2_x_reg, p2_y_reg;

    // best so far and first triangle result
    logic signed [CW-1:0] best_x_reg, best_y_reg, o1_x_reg, o1_y_reg;
    logic [D2W-1:0] best_d2_reg, o1_d2_reg;
    res_t res_reg;

    // dividers for the long and the short edge
    logic div_start;
    logic signed [NW-1:0] num_l, num_s;
    logic [DW-1:0] den_l, den_s;
    logic busy_l, busy_s;
    logic signed [CW-1:0] q_l, q_s;

    noc_div u_div_long (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_l),
        .den   (den_l),
        .busy  (busy_l),
        .quot  (q_l)
    );

    noc_div u_div_short (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_s),
        .den   (den_s),
        .busy  (busy_s),
        .quot  (q_s)
    );

    // sort the triangle vertices by row with three compare-swaps
    vtx_t s0, s1, s2, st;
    always_comb
    begin
        s0 = tri_reg ? d_reg : c_reg;
        s1 = tri_reg ? e_reg : d_reg;
        s2 = tri_reg ? f_reg : e_reg;
        st = s0;
        if (s0.y > s1.y)
        begin
            st = s0; s0 = s1; s1 = st;
        end
        if (s0.y > s2.y)
        begin
            st = s0; s0 = s2; s2 = st;
        end
        if (s1.y > s2.y)
        begin
            st = s1; s1 = s2; s2 = st;
        end
    end

    // edge products for the current row
    vtx_t e0, e1;
    logic signed [CW-1:0] hl_c, hs_c;
    logic signed [2*CW-1:0] pl1_c, pl2_c, ps1_c, ps2_c;
    logic [YW+XW:0] base_full;
    logic row_out;
    always_comb
    begin
        if (y_reg < sx(vb_reg.y))
        begin
            e0 = va_reg; e1 = vb_reg;
        end
        else
        begin
            e0 = vb_reg; e1 = vc_reg;
        end
        hl_c  = sx(vc_reg.y) - sx(va_reg.y);
        hs_c  = sx(e1.y) - sx(e0.y);
        pl1_c = sx(va_reg.x) * hl_c;
        pl2_c = (sx(vc_reg.x) - sx(va_reg.x)) * (y_reg - sx(va_reg.y));
        ps1_c = sx(e0.x) * hs_c;
        ps2_c = (sx(e1.x) - sx(e0.x)) * (y_reg - sx(e0.y));
        base_full = y_reg[YW-1:0] * w_reg[XW:0];
        row_out = (y_reg < 0) || (y_reg >= h_reg);
    end

    // numerators and divisors for rounding half up
    assign num_l = ((pl1_reg + pl2_reg) <<< 1) + NW'(hl_reg);
    assign num_s = ((ps1_reg + ps2_reg) <<< 1) + NW'(hs_reg);
    assign den_l = {hl_reg[DW-2:0], 1'b0};
    assign den_s = {hs_reg[DW-2:0], 1'b0};
    assign div_start = (state_reg == S_NUM);

    // span ends from the long and the short edge, ordered and clipped
    logic signed [CW-1:0] xs, xe, lo_c, hi_c;
    always_comb
    begin
        xs = q_l;
        xe = q_s;
        if (xs > xe)
        begin
            xs = q_s;
            xe = q_l;
        end
        lo_c = (xs < 0) ? '0 : xs;
        hi_c = (xe > w_reg) ? w_reg : xe;
    end

    logic issue;
    logic div_done;
    logic drained;
    assign issue    = (state_reg == S_SCAN) && (x_reg < hi_reg);
    assign div_done = !busy_l && !busy_s;
    assign drained  = !p1_valid_reg && !p2_valid_reg;
    assign rd_addr  = base_reg + AW'(x_reg[XW-1:0]);

    // final compare stage
    logic [D2W-1:0] d2_c;
    logic take;
    logic signed [2*CW-1:0] sqx_full, sqy_full;
    assign sqx_full = p1_dx_reg * p1_dx_reg;
    assign sqy_full = p1_dy_reg * p1_dy_reg;
    assign d2_c = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign take = p2_valid_reg && p2_occ_reg && (!best_hit_reg || (d2_c < best_d2_reg));

    // merge the two triangles; the second wins a tie
    logic use_o1, m_hit;
    logic signed [CW-1:0] m_x, m_y;
    logic [D2W-1:0] m_d2;
    res_t res_c;
    always_comb
    begin
        use_o1 = o1_hit_reg && (!best_hit_reg || (o1_d2_reg < best_d2_reg));
        m_hit  = use_o1 || best_hit_reg;
        m_x    = use_o1 ? o1_x_reg : best_x_reg;
        m_y    = use_o1 ? o1_y_reg : best_y_reg;
        m_d2   = use_o1 ? o1_d2_reg : best_d2_reg;
        res_c  = '0;
        if (m_hit)
        begin
            res_c.found = 1'b1;
            res_c.x     = m_x[OUT_XW-1:0];
            res_c.y     = m_y[OUT_XW-1:0];
            res_c.d2    = (m_d2 > D2W'(DIST_MAX)) ? DIST_MAX : m_d2[DIST_W-1:0];
        end
    end

    // load handling
    assign q_pop = (state_reg == S_IDLE) && q_valid;
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[AW-1:0];
        ptr_next  = ptr_reg;
        if (q_pop && !q_req.is_query)
        begin
            if (q_req.at_start)
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                ptr_next  = (AW+1)'(1);
            end
            else if (ptr_reg < (AW+1)'(CAP))
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        tri_next      = tri_reg;
        best_hit_next = best_hit_reg || take;
        o1_hit_next   = o1_hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop && q_req.is_query)
                begin
                    tri_next   = 1'b0;
                    state_next = S_SORT;
                end
            end
            S_SORT:
            begin
                best_hit_next = 1'b0;
                state_next    = S_ROW;
            end
            S_ROW:
            begin
                if (y_reg >= sx(vc_reg.y))
                begin
                    state_next = S_DRAIN;
                end
                else if (!row_out)
                begin
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue)
                begin
                    state_next = S_ROW;
                end
            end
            S_DRAIN:
            begin
                if (drained)
                begin
                    if (!tri_reg)
                    begin
                        o1_hit_next = best_hit_reg;
                        tri_next    = 1'b1;
                        state_next  = S_SORT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tri_reg      <= 1'b0;
            ptr_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            best_hit_reg <= 1'b0;
            o1_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tri_reg      <= tri_next;
            ptr_reg      <= ptr_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            best_hit_reg <= best_hit_next;
            o1_hit_reg   <= o1_hit_next;
        end
    end

    // occupancy write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_req.occ;
        end
        rd_bit_reg <= mem[rd_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop && q_req.is_query)
        begin
            rx_reg <= sx(q_req.rx);
            ry_reg <= sx(q_req.ry);
            c_reg  <= q_req.c;
            d_reg  <= q_req.d;
            e_reg  <= q_req.e;
            f_reg  <= q_req.f;
            w_reg  <= ({{(CW-CFG_W){1'b0}}, map_width} > CW'(MAX_WIDTH)) ?
                      CW'(MAX_WIDTH) : {{(CW-CFG_W){1'b0}}, map_width};
            h_reg  <= ({{(CW-CFG_W){1'b0}}, map_height} > CW'(MAX_HEIGHT)) ?
                      CW'(MAX_HEIGHT) : {{(CW-CFG_W){1'b0}}, map_height};
        end
        if (state_reg == S_SORT)
        begin
            va_reg <= s0;
            vb_reg <= s1;
            vc_reg <= s2;
            y_reg  <= sx(s0.y);
        end
        if (state_reg == S_ROW)
        begin
            pl1_reg  <= pl1_c;
            pl2_reg  <= pl2_c;
            ps1_reg  <= ps1_c;
            ps2_reg  <= ps2_c;
            hl_reg   <= hl_c;
            hs_reg   <= hs_c;
            base_reg <= base_full[AW-1:0];
            if (row_out && (y_reg < sx(vc_reg.y)))
            begin
                y_reg <= y_reg + 1'b1;
            end
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            x_reg  <= lo_c;
            hi_reg <= hi_c;
        end
        if (state_reg == S_SCAN)
        begin
            if (issue)
            begin
                x_reg <= x_reg + 1'b1;
            end
            else
            begin
                y_reg <= y_reg + 1'b1;
            end
        end
        // scan pipeline payload
        p1_dx_reg  <= x_reg - rx_reg;
        p1_dy_reg  <= y_reg - ry_reg;
        p1_x_reg   <= x_reg;
        p1_y_reg   <= y_reg;
        sqx_reg    <= sqx_full[SQW-1:0];
        sqy_reg    <= sqy_full[SQW-1:0];
        p2_occ_reg <= rd_bit_reg;
        p2_x_reg   <= p1_x_reg;
        p2_y_reg   <= p1_y_reg;
        if (take)
        begin
            best_x_reg  <= p2_x_reg;
            best_y_reg  <= p2_y_reg;
            best_d2_reg <= d2_c;
        end
        if ((state_reg == S_DRAIN) && drained)
        begin
            if (!tri_reg)
            begin
                o1_x_reg  <= best_x_reg;
                o1_y_reg  <= best_y_reg;
                o1_d2_reg <= best_d2_reg;
            end
            else
            begin
                res_reg <= res_c;
            end
        end
    end

    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ===== rtl/nearest_occupied_cell_in_area_core.sv =====
// Top level of the nearest occupied cell search: configuration, front, back and result register.
//
// Loads are applied by the back end as they leave the queue; a two-deep request queue in front
// lets new requests arrive while a query runs. A query leaves the queue and then scans triangle
// CDE and then DEF. Per triangle it sorts the vertices, steps through the rows, closes the row
// loop and drains the cell pipeline. A row that lies outside the map is only stepped over;
// each row inside it goes through row setup, divider start, a wait on the serial 24-step edge
// dividers and the closing scan step, with a scan of each cell of its
// span. The result then waits in the back end until the output register is free and passes
// through it. The occupancy store is not cleared at reset, so a query must only cover cells
// that have been loaded.
module nearest_occupied_cell_in_area_core import noc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             op,
    input  logic signed [7:0]      cell_value,
    input  logic signed [IN_W-1:0] robot_x,
    input  logic signed [IN_W-1:0] robot_y,
    input  logic signed [IN_W-1:0] corner_c_x,
    input  logic signed [IN_W-1:0] corner_c_y,
    input  logic signed [IN_W-1:0] corner_d_x,
    input  logic signed [IN_W-1:0] corner_d_y,
    input  logic signed [IN_W-1:0] corner_e_x,
    input  logic signed [IN_W-1:0] corner_e_y,
    input  logic signed [IN_W-1:0] corner_f_x,
    input  logic signed [IN_W-1:0] corner_f_y,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [OUT_XW-1:0]      hit_x,
    output logic [OUT_XW-1:0]      hit_y,
    output logic [DIST_W-1:0]      dist_sq
);

    logic [CFG_W-1:0] map_width_reg, map_height_reg;
    logic q_valid, q_pop;
    req_t q_req;
    logic res_valid, res_ready;
    res_t res;
    logic out_valid_reg;
    res_t out_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= CFG_W'(128);
            map_height_reg <= CFG_W'(128);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    noc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .cell_value (cell_value),
        .robot_x    (robot_x),
        .robot_y    (robot_y),
        .corner_c_x (corner_c_x),
        .corner_c_y (corner_c_y),
        .corner_d_x (corner_d_x),
        .corner_d_y (corner_d_y),
        .corner_e_x (corner_e_x),
        .corner_e_y (corner_e_y),
        .corner_f_x (corner_f_x),
        .corner_f_y (corner_f_y),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop)
    );

    noc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // result register: take a new result once the old one has gone
    assign res_ready = !out_valid_reg || !out_stall;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_reg.found;
    assign hit_x     = out_reg.x;
    assign hit_y     = out_reg.y;
    assign dist_sq   = out_reg.d2;

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (hit_x == '0 && hit_y == '0 && dist_sq == '0))
        else $error("miss result with nonzero fields");

    // the back end holds its result while the result register is occupied
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("back end result dropped while output busy");

endmodule

// ===== tb/sv/tb_nearest_occupied_cell_in_area_core.sv =====
// Self-checking testbench for the nearest occupied cell search core.
module tb_nearest_occupied_cell_in_area_core;
    import noc_pkg::*;

    localparam int CELLS    = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    // every map used below keeps width times height within this many cells
    localparam int PRELOAD  = 256;
    localparam int WD_LIMIT = 200000;
    localparam int OP_UNUSED = 3;

    typedef struct {
        logic [1:0]             opc;
        logic signed [7:0]      val;
        logic signed [IN_W-1:0] rx;
        logic signed [IN_W-1:0] ry;
        logic signed [IN_W-1:0] cor [8];
    } request_t;

    typedef struct {
        bit     hit;
        int     x;
        int     y;
        longint d2;
    } nearest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = REG_MAP_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] op = '0;
    logic signed [7:0] cell_value = '0;
    logic signed [IN_W-1:0] robot_x = '0, robot_y = '0;
    logic signed [IN_W-1:0] corner_c_x = '0, corner_c_y = '0;
    logic signed [IN_W-1:0] corner_d_x = '0, corner_d_y = '0;
    logic signed [IN_W-1:0] corner_e_x = '0, corner_e_y = '0;
    logic signed [IN_W-1:0] corner_f_x = '0, corner_f_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found;
    logic [OUT_XW-1:0] hit_x, hit_y;
    logic [DIST_W-1:0] dist_sq;

    // predictor state
    bit occ_map [CELLS];
    int load_ptr = 0;
    int cols = DEF_MAX_WIDTH;
    int rows = DEF_MAX_HEIGHT;
    res_t hit_q [$];

    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_req = 0;
    int burst_left = 0;

    nearest_occupied_cell_in_area_core u_top (.*);

    always #5 clk = ~clk;

    // floor division for a positive divisor
    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    // column on edge a->b at row y, rounded half up
    function automatic longint edge_col(longint ax, longint ay, longint bx, longint by_,
                                        longint y);
        longint h;
        h = by_ - ay;
        return fdiv(2 * (ax * h + (bx - ax) * (y - ay)) + h, 2 * h);
    endfunction

    function automatic nearest_t scan_tri(int rx, int ry, int vx [3], int vy [3]);
        nearest_t best;
        int t;
        longint xs, xe, lo, hi, dx, dy, d2;
        best = '{0, 0, 0, 0};
        // order the vertices by row
        if (vy[0] > vy[1]) begin t = vx[0]; vx[0] = vx[1]; vx[1] = t;
            t = vy[0]; vy[0] = vy[1]; vy[1] = t; end
        if (vy[0] > vy[2]) begin t = vx[0]; vx[0] = vx[2]; vx[2] = t;
            t = vy[0]; vy[0] = vy[2]; vy[2] = t; end
        if (vy[1] > vy[2]) begin t = vx[1]; vx[1] = vx[2]; vx[2] = t;
            t = vy[1]; vy[1] = vy[2]; vy[2] = t; end
        for (int y = vy[0]; y < vy[2]; y++) begin
            if (y < 0 || y >= rows)
                continue;
            xs = edge_col(vx[0], vy[0], vx[2], vy[2], y);
            xe = (y < vy[1]) ? edge_col(vx[0], vy[0], vx[1], vy[1], y)
                             : edge_col(vx[1], vy[1], vx[2], vy[2], y);
            if (xs > xe) begin lo = xs; xs = xe; xe = lo; end
            lo = xs < 0 ? 0 : xs;
            hi = xe > cols ? cols : xe;
            for (longint x = lo; x < hi; x++) begin
                if (occ_map[y * cols + x]) begin
                    dx = x - rx;
                    dy = y - ry;
                    d2 = dx * dx + dy * dy;
                    if (!best.hit || d2 < best.d2)
                        best = '{1, int'(x), y, d2};
                end
            end
        end
        return best;
    endfunction

    // apply one accepted request to the predictor
    task automatic predict_request(request_t r);
        nearest_t a, b, w;
        int xs [3], ys [3];
        res_t e;
        bit occ_bit;
        occ_bit = (r.val != 8'sd0 && r.val != -8'sd1);
        if (r.opc == OP_LOAD_NEXT) begin
            if (load_ptr < CELLS) begin
                occ_map[load_ptr] = occ_bit;
                load_ptr++;
            end
        end else if (r.opc == OP_LOAD_START) begin
            occ_map[0] = occ_bit;
            load_ptr = 1;
        end else if (r.opc == OP_QUERY) begin
            xs = '{r.cor[0], r.cor[2], r.cor[4]};
            ys = '{r.cor[1], r.cor[3], r.cor[5]};
            a = scan_tri(r.rx, r.ry, xs, ys);
            xs = '{r.cor[2], r.cor[4], r.cor[6]};
            ys = '{r.cor[3], r.cor[5], r.cor[7]};
            b = scan_tri(r.rx, r.ry, xs, ys);
            w = (a.hit && (!b.hit || a.d2 < b.d2)) ? a : b;
            e = '0;
            if (w.hit) begin
                e.found = 1'b1;
                e.x = w.x[OUT_XW-1:0];
                e.y = w.y[OUT_XW-1:0];
                e.d2 = (w.d2 > longint'(DIST_MAX)) ? DIST_MAX : w.d2[DIST_W-1:0];
            end
            hit_q.push_back(e);
        end
    endtask

    // present one request, hold until accepted, then apply burst spacing
    task automatic send_request(request_t r);
        op <= r.opc;
        cell_value <= r.val;
        robot_x <= r.rx;
        robot_y <= r.ry;
        corner_c_x <= r.cor[0]; corner_c_y <= r.cor[1];
        corner_d_x <= r.cor[2]; corner_d_y <= r.cor[3];
        corner_e_x <= r.cor[4]; corner_e_y <= r.cor[5];
        corner_f_x <= r.cor[6]; corner_f_y <= r.cor[7];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(r);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // sparse occupancy: mostly free or unknown bytes
    function automatic logic signed [7:0] rand_cell();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'sd0;
            3, 4:    return -8'sd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic request_t load_req(logic [1:0] o, logic signed [7:0] v);
        request_t r;
        r.opc = o;
        r.val = v;
        r.rx = IN_W'($urandom);
        r.ry = IN_W'($urandom);
        foreach (r.cor[i]) r.cor[i] = IN_W'($urandom);
        return r;
    endfunction

    function automatic request_t query_req(int cx, int cy, int span, bit wide);
        request_t r;
        r = load_req(OP_QUERY, 8'($urandom));
        if (wide)
            return r;
        foreach (r.cor[i])
            r.cor[i] = IN_W'(((i % 2) ? cy : cx)
                             + $signed($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 4) != 0) begin
            r.rx = IN_W'(cx + $signed($urandom_range(0, 40)) - 20);
            r.ry = IN_W'(cy + $signed($urandom_range(0, 40)) - 20);
        end
        return r;
    endfunction

    function automatic request_t random_req();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return load_req(OP_LOAD_NEXT, rand_cell());
        if (k < 47) return load_req(OP_LOAD_START, rand_cell());
        if (k < 49) return load_req(2'(OP_UNUSED), 8'($urandom));
        if (k < 51) return query_req(0, 0, 0, 1);
        return query_req(int'($urandom_range(0, cols + 8)) - 4,
                         int'($urandom_range(0, rows + 8)) - 4,
                         int'($urandom_range(1, 14)), 0);
    endfunction

    task automatic wait_drained();
        while (hit_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MAP_WIDTH)
            cols = (v > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(v);
        else
            rows = (v > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_map(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_drained();
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
    endtask

    // write the low cells once so no query reads an unwritten cell
    task automatic test_preload();
        for (int i = 0; i < PRELOAD; i++)
            send_request(load_req(OP_LOAD_NEXT, rand_cell()));
        end_burst();
    endtask

    task automatic test_directed();
        request_t r;
        logic signed [7:0] vals [5] = '{8'sd0, -8'sd1, 8'sd1, -8'sd128, 8'sd127};
        set_map(8'd16, 8'd16);
        // load at start, then next cells, with the byte extremes
        send_request(load_req(OP_LOAD_START, 8'sd5));
        foreach (vals[i])
            send_request(load_req(OP_LOAD_NEXT, vals[i]));
        send_request(load_req(2'(OP_UNUSED), 8'sd9));
        // query covering the freshly loaded corner of the map
        r = query_req(0, 0, 0, 0);
        r.cor = '{-2, -2, 8, -2, -2, 3, 8, 3};
        r.rx = 0; r.ry = 0;
        send_request(r);
        // degenerate triangles: all corners on one row
        r.cor = '{0, 5, 40, 5, 90, 5, 120, 5};
        send_request(r);
        // corner extremes
        r.cor = '{-512, -512, 511, -512, -512, 511, 511, 511};
        r.rx = -512; r.ry = 511;
        send_request(r);
        r.cor = '{511, 511, -512, 511, 511, -512, -512, -512};
        r.rx = 511; r.ry = -512;
        send_request(r);
        // tie between the triangles, robot centred
        r.cor = '{2, 2, 12, 2, 2, 12, 12, 12};
        r.rx = 7; r.ry = 7;
        send_request(r);
        end_burst();
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_request(random_req());
        end_burst();
    endtask

    // keep every map within the preloaded cells
    task automatic test_map_sizes();
        set_map(8'd1, 8'd1);
        run_random(40);
        set_map(8'd0, 8'd5);
        run_random(20);
        set_map(8'd7, 8'd0);
        run_random(20);
        set_map(8'd255, 8'd2);
        run_random(30);
        set_map(8'd1, 8'd255);
        run_random(30);
        set_map(8'(DEF_MAX_WIDTH), 8'd1);
        run_random(40);
        set_map(8'($urandom_range(8, 32)), 8'($urandom_range(4, 8)));
        run_random(120);
        set_map(8'($urandom_range(129, 255)), 8'($urandom_range(1, 2)));
        run_random(60);
    endtask

    // hold the result side off long enough for the request queue to fill
    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 20; i++)
            send_request(query_req($urandom_range(0, cols), $urandom_range(0, rows), 2, 0));
        end_burst();
    endtask

    task automatic test_drain_pause();
        run_random(40);
        while (hit_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
        run_random(100);
    endtask

    // result side stall pattern
    initial begin
        int mode, left, hold;
        mode = 0; left = 0; hold = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 0;
                hold = 600;
            end
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(20, 200);
                end
                left--;
                out_stall <= (mode == 0) ? 1'b0 :
                             (mode == 1) ? 1'($urandom_range(0, 1)) :
                                           1'($urandom_range(0, 7) != 0);
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        res_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (hit_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result found=%0d x=%0d y=%0d d2=%0d",
                             found, hit_x, hit_y, dist_sq);
            end else begin
                e = hit_q.pop_front();
                if (found !== e.found || hit_x !== e.x || hit_y !== e.y
                        || dist_sq !== e.d2) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 e.found, e.x, e.y, e.d2, found, hit_x, hit_y, dist_sq);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL nearest_occupied_cell_in_area_core");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);
        test_preload();
        test_directed();
        test_map_sizes();
        set_map(8'($urandom_range(16, 32)), 8'd8);
        test_backpressure();
        test_drain_pause();
        while (hit_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && hit_q.size() == 0)
            $display("PASS nearest_occupied_cell_in_area_core");
        else
            $display("FAIL nearest_occupied_cell_in_area_core");
        $finish;
    end

endmodule
